// File: rtl/rubbg_pkg.sv
// ----------------------------------------------------------------------------
// rubbg_pkg: shared types and constants of the unit-ball body generator
// Field widths, register codes, sequencer states and the structs passed
// between the front queue, the engine and the reciprocal divider.
// ----------------------------------------------------------------------------
package rubbg_pkg;

   localparam int SEED_W    = 31;
   localparam int SCALE_W   = 24;
   localparam int COORD_W   = 32;
   localparam int OUT_W     = 32;
   localparam int MASS_W    = 31;
   localparam int INV_W     = 32;
   localparam int PROD_W    = 64;
   localparam int DIMS      = 3;
   localparam int CSR_IDX_W = 2;
   localparam int CSR_DAT_W = 31;

   localparam int QUEUE_DEPTH_DEF = 2;
   localparam int DIV_BITS_PER_CYCLE = 2;

   localparam logic [SEED_W-1:0]  LCG_MUL     = 31'd214013;
   localparam logic [SEED_W-1:0]  LCG_ADD     = 31'd2531011;
   localparam logic [SEED_W-1:0]  SEED_RESET  = 31'd1;
   localparam logic [SCALE_W-1:0] SCALE_RESET = 24'd65536;
   localparam logic [COORD_W-1:0] COORD_HALF  = 32'h8000_0000;
   localparam logic [PROD_W-1:0]  ONE_Q62     = 64'h4000_0000_0000_0000;
   localparam logic [MASS_W-1:0]  DIV_REM_INIT = 31'h2000_0000;

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_SEED      = 2'd0,
      REG_POS_SCALE = 2'd1,
      REG_VEL_SCALE = 2'd2
   } reg_index_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DRAW,
      ST_SETTLE,
      ST_CHECK,
      ST_MASS,
      ST_SCALE,
      ST_WAIT
   } state_type;

   typedef struct packed {
      logic valid;
      logic reseed;
   } job_type;

   typedef struct packed {
      logic              start;
      logic [MASS_W-1:0] divisor;
   } div_ctl_type;

   typedef struct packed {
      logic             done;
      logic [INV_W-1:0] quotient;
   } div_sts_type;

endpackage

// File: rtl/rubbg_ifs.sv
// ----------------------------------------------------------------------------
// rubbg_ifs: request and response channels
// Valid/ready channels; a word moves on an edge with valid and ready high.
// ----------------------------------------------------------------------------
interface rubbg_req_if;
   logic valid;
   logic ready;
   logic reseed;

   modport source (output valid, output reseed, input ready);
   modport sink   (input valid, input reseed, output ready);
endinterface

interface rubbg_rsp_if;
   logic                            valid;
   logic                            ready;
   logic [rubbg_pkg::OUT_W-1:0]     pos_x;
   logic [rubbg_pkg::OUT_W-1:0]     pos_y;
   logic [rubbg_pkg::OUT_W-1:0]     pos_z;
   logic [rubbg_pkg::MASS_W-1:0]    mass;
   logic [rubbg_pkg::OUT_W-1:0]     vel_x;
   logic [rubbg_pkg::OUT_W-1:0]     vel_y;
   logic [rubbg_pkg::OUT_W-1:0]     vel_z;
   logic [rubbg_pkg::INV_W-1:0]     inv_mass;

   modport source (output valid, output pos_x, output pos_y, output pos_z, output mass,
                   output vel_x, output vel_y, output vel_z, output inv_mass, input ready);
   modport sink   (input valid, input pos_x, input pos_y, input pos_z, input mass,
                   input vel_x, input vel_y, input vel_z, input inv_mass, output ready);
endinterface

// File: rtl/random_unit_ball_body_generator_top.sv
// ----------------------------------------------------------------------------
// random_unit_ball_body_generator_top: random body generator
// Each request word yields one body: position and velocity drawn inside
// the unit ball by rejection, scaled to Q16.16, plus mass and its reciprocal.
// ----------------------------------------------------------------------------
// A body repeats its point attempts until both points lie in the ball
// (each attempt is three serial generator draws and the settling of the
// shared squaring multiplier); the mass reciprocal comes from the
// two-bit-per-cycle reciprocal divider.
// Requests queue in front while a body is in work, and a finished word
// waits in the response register while the next body is computed. Write
// the seed and scale registers only while the block is idle; a new seed
// takes effect at the next request with reseed set.
module random_unit_ball_body_generator_top #(
   parameter int QUEUE_DEPTH = rubbg_pkg::QUEUE_DEPTH_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   rubbg_req_if.sink                           req_if,
   rubbg_rsp_if.source                         rsp_if,
   input  logic                                csr_we,
   input  logic [rubbg_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [rubbg_pkg::CSR_DAT_W-1:0]     csr_wdata
);

   logic [rubbg_pkg::SEED_W-1:0]  seed_ff;
   logic [rubbg_pkg::SCALE_W-1:0] pos_scale_ff;
   logic [rubbg_pkg::SCALE_W-1:0] vel_scale_ff;
   rubbg_pkg::job_type            job;
   logic                          job_pop;
   rubbg_pkg::div_ctl_type        div_ctl;
   rubbg_pkg::div_sts_type        div_sts;

   always_ff @(posedge clock) begin
      if (reset) begin
         seed_ff      <= rubbg_pkg::SEED_RESET;
         pos_scale_ff <= rubbg_pkg::SCALE_RESET;
         vel_scale_ff <= rubbg_pkg::SCALE_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            rubbg_pkg::REG_SEED: begin
               seed_ff <= csr_wdata[rubbg_pkg::SEED_W-1:0];
            end
            rubbg_pkg::REG_POS_SCALE: begin
               pos_scale_ff <= csr_wdata[rubbg_pkg::SCALE_W-1:0];
            end
            rubbg_pkg::REG_VEL_SCALE: begin
               vel_scale_ff <= csr_wdata[rubbg_pkg::SCALE_W-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   rubbg_front #(
      .QUEUE_DEPTH (QUEUE_DEPTH)
   ) u_front (
      .clock   (clock),
      .reset   (reset),
      .req_if  (req_if),
      .job     (job),
      .job_pop (job_pop)
   );

   rubbg_engine u_engine (
      .clock     (clock),
      .reset     (reset),
      .seed      (seed_ff),
      .pos_scale (pos_scale_ff),
      .vel_scale (vel_scale_ff),
      .job       (job),
      .job_pop   (job_pop),
      .div_ctl   (div_ctl),
      .div_sts   (div_sts),
      .rsp_if    (rsp_if)
   );

   rubbg_div u_div (
      .clock (clock),
      .reset (reset),
      .ctl   (div_ctl),
      .sts   (div_sts)
   );

endmodule

// File: rtl/rubbg_front.sv
// ----------------------------------------------------------------------------
// rubbg_front: request intake
// Accepts request words and queues their reseed flag for the engine.
// ----------------------------------------------------------------------------
module rubbg_front #(
   parameter int QUEUE_DEPTH = rubbg_pkg::QUEUE_DEPTH_DEF
) (
   input  logic                clock,
   input  logic                reset,
   rubbg_req_if.sink           req_if,
   output rubbg_pkg::job_type  job,
   input  logic                job_pop
);

   localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
   localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);
   localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(QUEUE_DEPTH);

   logic             slot_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             push;
   logic             pop;

   assign req_if.ready = (count_ff != CNT_FULL);
   assign push = req_if.valid && req_if.ready;
   assign pop  = job_pop && (count_ff != '0);

   assign job.valid  = (count_ff != '0);
   assign job.reseed = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_LAST) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_LAST) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= req_if.reseed;
      end
   end

endmodule

// File: rtl/rubbg_div.sv
// ----------------------------------------------------------------------------
// rubbg_div: reciprocal of the mass
// Restoring division of 2^61 by the mass, two quotient bits per cycle.
// ----------------------------------------------------------------------------
module rubbg_div (
   input  logic                    clock,
   input  logic                    reset,
   input  rubbg_pkg::div_ctl_type  ctl,
   output rubbg_pkg::div_sts_type  sts
);

   localparam int MW    = rubbg_pkg::MASS_W;
   localparam int QW    = rubbg_pkg::INV_W;
   localparam int BPC   = rubbg_pkg::DIV_BITS_PER_CYCLE;
   localparam int STEPS = QW / BPC;
   localparam int CNT_W = (STEPS > 1) ? $clog2(STEPS) : 1;
   localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(STEPS - 1);

   logic [MW-1:0]    rem_ff, rem_in;
   logic [QW-1:0]    quo_ff, quo_in;
   logic [MW-1:0]    divisor_ff;
   logic [CNT_W-1:0] cnt_ff;
   logic             busy_ff;
   logic             done_ff;

   assign sts.done     = done_ff;
   assign sts.quotient = quo_ff;

   always_comb begin
      logic [MW:0] shifted;
      logic [MW:0] diff;
      rem_in = rem_ff;
      quo_in = quo_ff;
      for (int i = 0; i < BPC; i++) begin
         shifted = {rem_in, 1'b0};
         diff    = shifted - {1'b0, divisor_ff};
         if (shifted >= {1'b0, divisor_ff}) begin
            rem_in = diff[MW-1:0];
            quo_in = {quo_in[QW-2:0], 1'b1};
         end else begin
            rem_in = shifted[MW-1:0];
            quo_in = {quo_in[QW-2:0], 1'b0};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else if (ctl.start) begin
         busy_ff <= 1'b1;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else if (busy_ff) begin
         cnt_ff <= cnt_ff + 1'b1;
         if (cnt_ff == CNT_LAST) begin
            busy_ff <= 1'b0;
            done_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.start) begin
         rem_ff     <= rubbg_pkg::DIV_REM_INIT;
         quo_ff     <= '0;
         divisor_ff <= ctl.divisor;
      end else if (busy_ff) begin
         rem_ff <= rem_in;
         quo_ff <= quo_in;
      end
   end

endmodule

// File: rtl/rubbg_engine.sv
// ----------------------------------------------------------------------------
// rubbg_engine: body sequencer
// Draws and tests points, draws the mass, scales the coordinates and
// holds the finished word in the response register.
// ----------------------------------------------------------------------------
module rubbg_engine (
   input  logic                              clock,
   input  logic                              reset,
   input  logic [rubbg_pkg::SEED_W-1:0]      seed,
   input  logic [rubbg_pkg::SCALE_W-1:0]     pos_scale,
   input  logic [rubbg_pkg::SCALE_W-1:0]     vel_scale,
   input  rubbg_pkg::job_type                job,
   output logic                              job_pop,
   output rubbg_pkg::div_ctl_type            div_ctl,
   input  rubbg_pkg::div_sts_type            div_sts,
   rubbg_rsp_if.source                       rsp_if
);

   localparam int SW        = rubbg_pkg::SEED_W;
   localparam int CW        = rubbg_pkg::COORD_W;
   localparam int PW        = rubbg_pkg::PROD_W;
   localparam int OW        = rubbg_pkg::OUT_W;
   localparam int MW        = rubbg_pkg::MASS_W;
   localparam int DIMS      = rubbg_pkg::DIMS;
   localparam int NUM_COORD = 2 * DIMS;
   localparam int IDX_W     = $clog2(NUM_COORD);
   localparam logic [IDX_W-1:0] IDX_DIMS = IDX_W'(DIMS);
   localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(NUM_COORD - 1);
   localparam logic [IDX_W-1:0] DRAW_LAST = IDX_W'(DIMS - 1);
   localparam logic [IDX_W-1:0] SETTLE_LAST = IDX_W'(1);

   function automatic logic [CW-1:0] coord_mag(input logic [SW-1:0] v);
      logic [CW-1:0] twice;
      twice = {v, 1'b0};
      if (v[SW-1]) begin
         coord_mag = twice - rubbg_pkg::COORD_HALF;
      end else begin
         coord_mag = rubbg_pkg::COORD_HALF - twice;
      end
   endfunction

   function automatic logic [OW-1:0] scale_sat(input logic [PW-1:0] p, input logic neg);
      logic [OW:0] sh;
      sh = p[PW-1:PW-OW-1];
      if (neg) begin
         scale_sat = (sh > {1'b0, rubbg_pkg::COORD_HALF}) ? rubbg_pkg::COORD_HALF
                                                           : OW'((OW+1)'(0) - sh);
      end else begin
         scale_sat = (sh > {2'b00, {(OW-1){1'b1}}}) ? {1'b0, {(OW-1){1'b1}}} : sh[OW-1:0];
      end
   endfunction

   rubbg_pkg::state_type state_ff, state_in;
   logic [IDX_W-1:0] cnt_ff, cnt_in;
   logic             phase_ff, phase_in;
   logic [SW-1:0]    lcg_ff, lcg_in;
   logic [SW-1:0]    lcg_next;
   logic [PW-1:0]    acc_ff, acc_in;
   logic [PW-1:0]    prod_ff;
   logic [CW-1:0]    mul_a;
   logic [CW-1:0]    mul_b;
   logic             sq_req_ff, sq_req_in;
   logic             sq_vld_ff;
   logic             sc_vld_ff, sc_vld_in;
   logic [IDX_W-1:0] sc_idx_ff, sc_idx_in;
   logic             sc_neg_ff, sc_neg_in;
   logic [MW-1:0]    mass_ff, mass_in;
   logic [SW-1:0]    coord_ff [NUM_COORD];
   logic [OW-1:0]    res_ff [NUM_COORD];
   logic [OW-1:0]    out_res_ff [NUM_COORD];
   logic [MW-1:0]    out_mass_ff;
   logic [rubbg_pkg::INV_W-1:0] out_inv_ff;
   logic             rsp_valid_ff, rsp_valid_in;
   logic             draw_wr;
   logic [IDX_W-1:0] draw_idx;
   logic             load_out;

   assign lcg_next = lcg_ff * rubbg_pkg::LCG_MUL + rubbg_pkg::LCG_ADD;
   assign draw_idx = phase_ff ? cnt_ff + IDX_DIMS : cnt_ff;

   always_comb begin
      state_in  = state_ff;
      cnt_in    = cnt_ff;
      phase_in  = phase_ff;
      lcg_in    = lcg_ff;
      acc_in    = sq_vld_ff ? acc_ff + prod_ff : acc_ff;
      sq_req_in = 1'b0;
      sc_vld_in = 1'b0;
      sc_idx_in = sc_idx_ff;
      sc_neg_in = sc_neg_ff;
      mass_in   = mass_ff;
      job_pop   = 1'b0;
      draw_wr   = 1'b0;
      load_out  = 1'b0;
      mul_a     = coord_mag(lcg_ff);
      mul_b     = coord_mag(lcg_ff);
      div_ctl.start   = 1'b0;
      div_ctl.divisor = {1'b1, lcg_next[SW-1:1]};
      unique case (state_ff)
         rubbg_pkg::ST_IDLE: begin
            if (job.valid) begin
               job_pop  = 1'b1;
               if (job.reseed) begin
                  lcg_in = seed;
               end
               acc_in   = '0;
               phase_in = 1'b0;
               cnt_in   = '0;
               state_in = rubbg_pkg::ST_DRAW;
            end
         end
         rubbg_pkg::ST_DRAW: begin
            lcg_in    = lcg_next;
            draw_wr   = 1'b1;
            sq_req_in = 1'b1;
            if (cnt_ff == DRAW_LAST) begin
               cnt_in   = '0;
               state_in = rubbg_pkg::ST_SETTLE;
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end
         rubbg_pkg::ST_SETTLE: begin
            if (cnt_ff == SETTLE_LAST) begin
               cnt_in   = '0;
               state_in = rubbg_pkg::ST_CHECK;
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end
         rubbg_pkg::ST_CHECK: begin
            acc_in = '0;
            cnt_in = '0;
            if (acc_ff > rubbg_pkg::ONE_Q62) begin
               phase_in = 1'b0;
               state_in = rubbg_pkg::ST_DRAW;
            end else if (!phase_ff) begin
               phase_in = 1'b1;
               state_in = rubbg_pkg::ST_DRAW;
            end else begin
               state_in = rubbg_pkg::ST_MASS;
            end
         end
         rubbg_pkg::ST_MASS: begin
            lcg_in        = lcg_next;
            mass_in       = div_ctl.divisor;
            div_ctl.start = 1'b1;
            cnt_in        = '0;
            state_in      = rubbg_pkg::ST_SCALE;
         end
         rubbg_pkg::ST_SCALE: begin
            mul_a     = coord_mag(coord_ff[cnt_ff]);
            mul_b     = (cnt_ff < IDX_DIMS) ? CW'(pos_scale) : CW'(vel_scale);
            sc_vld_in = 1'b1;
            sc_idx_in = cnt_ff;
            sc_neg_in = !coord_ff[cnt_ff][SW-1];
            if (cnt_ff == IDX_LAST) begin
               state_in = rubbg_pkg::ST_WAIT;
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end
         rubbg_pkg::ST_WAIT: begin
            if (!sc_vld_ff && div_sts.done && (!rsp_valid_ff || rsp_if.ready)) begin
               load_out = 1'b1;
               state_in = rubbg_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = rubbg_pkg::ST_IDLE;
         end
      endcase
      rsp_valid_in = load_out || (rsp_valid_ff && !rsp_if.ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= rubbg_pkg::ST_IDLE;
         cnt_ff       <= '0;
         phase_ff     <= 1'b0;
         lcg_ff       <= rubbg_pkg::SEED_RESET;
         sq_req_ff    <= 1'b0;
         sq_vld_ff    <= 1'b0;
         sc_vld_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         phase_ff     <= phase_in;
         lcg_ff       <= lcg_in;
         sq_req_ff    <= sq_req_in;
         sq_vld_ff    <= sq_req_ff;
         sc_vld_ff    <= sc_vld_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      acc_ff    <= acc_in;
      prod_ff   <= PW'(mul_a) * PW'(mul_b);
      sc_idx_ff <= sc_idx_in;
      sc_neg_ff <= sc_neg_in;
      mass_ff   <= mass_in;
      if (draw_wr) begin
         coord_ff[draw_idx] <= lcg_next;
      end
      if (sc_vld_ff) begin
         res_ff[sc_idx_ff] <= scale_sat(prod_ff, sc_neg_ff);
      end
      if (load_out) begin
         out_res_ff  <= res_ff;
         out_mass_ff <= mass_ff;
         out_inv_ff  <= div_sts.quotient;
      end
   end

   assign rsp_if.valid    = rsp_valid_ff;
   assign rsp_if.pos_x    = out_res_ff[0];
   assign rsp_if.pos_y    = out_res_ff[1];
   assign rsp_if.pos_z    = out_res_ff[2];
   assign rsp_if.vel_x    = out_res_ff[DIMS];
   assign rsp_if.vel_y    = out_res_ff[DIMS+1];
   assign rsp_if.vel_z    = out_res_ff[DIMS+2];
   assign rsp_if.mass     = out_mass_ff;
   assign rsp_if.inv_mass = out_inv_ff;

endmodule

// File: bench/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top: testbench of the random unit-ball body generator
// Sends request words with random gaps and takes the bodies with random
// stalls. A model of the generator, its rejection loop, scaling and
// reciprocal, predicts each body when its request is accepted. Every field
// of each response is checked against the oldest prediction. Seed and
// scales are rewritten, extremes included, only when the block is drained.
// ----------------------------------------------------------------------------
module tb_top;
   import rubbg_pkg::*;

   localparam logic [CSR_IDX_W-1:0] REG_SPARE = 2'd3;
   localparam int SETTLE_CYCLES = 40;
   localparam int STALL_LIMIT = 20000;

   typedef struct {
      logic [OUT_W-1:0]  pos_x;
      logic [OUT_W-1:0]  pos_y;
      logic [OUT_W-1:0]  pos_z;
      logic [MASS_W-1:0] mass;
      logic [OUT_W-1:0]  vel_x;
      logic [OUT_W-1:0]  vel_y;
      logic [OUT_W-1:0]  vel_z;
      logic [INV_W-1:0]  inv_mass;
   } body_type;

   logic                 clock;
   logic                 reset;
   logic                 csr_we;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [CSR_DAT_W-1:0] csr_wdata;

   rubbg_req_if req_if ();
   rubbg_rsp_if rsp_if ();

   random_unit_ball_body_generator_top dut (
      .clock     (clock),
      .reset     (reset),
      .req_if    (req_if),
      .rsp_if    (rsp_if),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   logic [SEED_W-1:0]  seed_reg;
   logic [SCALE_W-1:0] pos_scale_reg;
   logic [SCALE_W-1:0] vel_scale_reg;
   logic [SEED_W-1:0]  gen_state;

   logic     reseed_queue[$];
   body_type bodies_due[$];
   body_type due;

   int send_gap_pct;
   int take_stall_pct;
   int send_wait;
   int take_wait;
   int error_count;
   int bodies_seen;
   int idle_cycles;

   always #5 clock = ~clock;

   function automatic logic [SEED_W-1:0] lcg_step();
      logic [63:0] product;
      product = 64'(LCG_MUL) * 64'(gen_state) + 64'(LCG_ADD);
      gen_state = product[SEED_W-1:0];
      return gen_state;
   endfunction

   // coordinate 2v - 2^31 in units of 2^-31
   function automatic longint draw_coord();
      return longint'({33'd0, lcg_step()}) * 2 - (longint'(1) << 31);
   endfunction

   function automatic bit draw_in_ball(output longint pt[DIMS]);
      logic [63:0] len_sq;
      logic [63:0] mag;
      len_sq = '0;
      for (int k = 0; k < DIMS; k++) begin
         pt[k] = draw_coord();
         mag = pt[k] < 0 ? 64'(-pt[k]) : 64'(pt[k]);
         len_sq += mag * mag;
      end
      return len_sq <= ONE_Q62;
   endfunction

   function automatic logic [OUT_W-1:0] scale_coord(longint c, logic [SCALE_W-1:0] s);
      logic [63:0] mag;
      mag = c < 0 ? 64'(-c) : 64'(c);
      mag = (mag * 64'(s)) >> 31;
      if (c < 0)
         return (mag > 64'h8000_0000) ? 32'h8000_0000 : 32'(64'd0 - mag);
      return (mag > 64'h7FFF_FFFF) ? 32'h7FFF_FFFF : mag[OUT_W-1:0];
   endfunction

   function automatic body_type predict_body(logic reseed);
      longint   pos[DIMS];
      longint   vel[DIMS];
      bit       ok;
      logic [63:0] inv;
      body_type b;
      if (reseed)
         gen_state = seed_reg;
      // a rejected velocity restarts the whole body
      do begin
         ok = draw_in_ball(pos);
         if (ok)
            ok = draw_in_ball(vel);
      end while (!ok);
      b.mass = 31'h4000_0000 + (lcg_step() >> 1);
      inv = 64'h2000_0000_0000_0000 / 64'(b.mass);
      b.inv_mass = inv[INV_W-1:0];
      b.pos_x = scale_coord(pos[0], pos_scale_reg);
      b.pos_y = scale_coord(pos[1], pos_scale_reg);
      b.pos_z = scale_coord(pos[2], pos_scale_reg);
      b.vel_x = scale_coord(vel[0], vel_scale_reg);
      b.vel_y = scale_coord(vel[1], vel_scale_reg);
      b.vel_z = scale_coord(vel[2], vel_scale_reg);
      return b;
   endfunction

   function automatic int pick_pause(int pct);
      if ($urandom_range(99) >= pct)
         return 0;
      if ($urandom_range(9) < 8)
         return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   function automatic logic [CSR_DAT_W-1:0] pick_seed();
      case ($urandom_range(4))
         0: return '0;
         1: return '1;
         default: return CSR_DAT_W'($urandom);
      endcase
   endfunction

   // upper bits beyond the scale width are sometimes set and must be dropped
   function automatic logic [CSR_DAT_W-1:0] pick_scale();
      case ($urandom_range(3))
         0: return '0;
         1: return 31'h00FF_FFFF;
         2: return CSR_DAT_W'($urandom);
         default: return CSR_DAT_W'($urandom_range(24'hFF_FFFF));
      endcase
   endfunction

   task automatic check_field(string name, logic [31:0] exp, logic [31:0] act);
      if (exp !== act) begin
         $display("%0t body %0d %s: expected %h, actual %h", $time, bodies_seen, name,
                  exp, act);
         error_count++;
      end
   endtask

   task automatic write_reg(logic [CSR_IDX_W-1:0] idx, logic [CSR_DAT_W-1:0] value);
      @(posedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      csr_we <= 1'b0;
      case (idx)
         REG_SEED:      seed_reg = value[SEED_W-1:0];
         REG_POS_SCALE: pos_scale_reg = value[SCALE_W-1:0];
         REG_VEL_SCALE: vel_scale_reg = value[SCALE_W-1:0];
         default: ;
      endcase
   endtask

   task automatic queue_bodies(int count, int reseed_pct);
      repeat (count)
         reseed_queue.push_back($urandom_range(99) < reseed_pct);
   endtask

   // hold the sender until every body is back
   task automatic drain();
      while (reseed_queue.size() != 0 || req_if.valid || bodies_due.size() != 0)
         @(negedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   always @(posedge clock) begin
      if (reset) begin
         req_if.valid <= 1'b0;
         send_wait <= 0;
      end else begin
         if (req_if.valid && req_if.ready)
            bodies_due.push_back(predict_body(req_if.reseed));
         if (!req_if.valid || req_if.ready) begin
            if (send_wait > 0) begin
               send_wait <= send_wait - 1;
               req_if.valid <= 1'b0;
            end else if (reseed_queue.size() != 0) begin
               req_if.valid <= 1'b1;
               req_if.reseed <= reseed_queue.pop_front();
               send_wait <= pick_pause(send_gap_pct);
            end else begin
               req_if.valid <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         rsp_if.ready <= 1'b0;
         take_wait <= 0;
      end else begin
         if (rsp_if.valid && rsp_if.ready) begin
            if (bodies_due.size() == 0) begin
               $display("%0t body %0d: word with nothing expected, actual pos_x %h",
                        $time, bodies_seen, rsp_if.pos_x);
               error_count++;
            end else begin
               due = bodies_due.pop_front();
               check_field("pos_x", due.pos_x, rsp_if.pos_x);
               check_field("pos_y", due.pos_y, rsp_if.pos_y);
               check_field("pos_z", due.pos_z, rsp_if.pos_z);
               check_field("mass", 32'(due.mass), 32'(rsp_if.mass));
               check_field("vel_x", due.vel_x, rsp_if.vel_x);
               check_field("vel_y", due.vel_y, rsp_if.vel_y);
               check_field("vel_z", due.vel_z, rsp_if.vel_z);
               check_field("inv_mass", due.inv_mass, rsp_if.inv_mass);
            end
            bodies_seen++;
         end
         if (take_wait > 0) begin
            take_wait <= take_wait - 1;
            rsp_if.ready <= 1'b0;
         end else begin
            rsp_if.ready <= 1'b1;
            take_wait <= pick_pause(take_stall_pct);
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= STALL_LIMIT) begin
         $display("%0t watchdog: no word moved for %0d cycles", $time, idle_cycles);
         $display("tb_top: errors");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      clock = 1'b0;
      reset = 1'b1;
      req_if.valid = 1'b0;
      req_if.reseed = 1'b0;
      rsp_if.ready = 1'b0;
      csr_we = 1'b0;
      csr_index = '0;
      csr_wdata = '0;
      seed_reg = SEED_RESET;
      pos_scale_reg = SCALE_RESET;
      vel_scale_reg = SCALE_RESET;
      gen_state = SEED_RESET;
      error_count = 0;
      bodies_seen = 0;
      idle_cycles = 0;
      send_wait = 0;
      take_wait = 0;
      send_gap_pct = 30;
      take_stall_pct = 30;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // registers at their reset values
      reseed_queue.push_back(1'b0);
      reseed_queue.push_back(1'b0);
      reseed_queue.push_back(1'b1);
      reseed_queue.push_back(1'b0);
      drain();

      // zero seed, full position scale, zero velocity scale
      write_reg(REG_SEED, '0);
      write_reg(REG_POS_SCALE, 31'h00FF_FFFF);
      write_reg(REG_VEL_SCALE, '0);
      reseed_queue.push_back(1'b1);
      reseed_queue.push_back(1'b0);
      reseed_queue.push_back(1'b0);
      drain();

      // top seed, swapped scale extremes, write to the spare index
      write_reg(REG_SEED, 31'h7FFF_FFFF);
      write_reg(REG_POS_SCALE, '0);
      write_reg(REG_VEL_SCALE, 31'h00FF_FFFF);
      write_reg(REG_SPARE, 31'h7FFF_FFFF);
      reseed_queue.push_back(1'b1);
      reseed_queue.push_back(1'b1);
      reseed_queue.push_back(1'b0);
      drain();

      // new seed stays unused until a reseed request
      write_reg(REG_SEED, 31'd12345);
      reseed_queue.push_back(1'b0);
      reseed_queue.push_back(1'b1);
      drain();

      // drop scale bits above the register width
      write_reg(REG_POS_SCALE, 31'h7FFF_FFFF);
      write_reg(REG_VEL_SCALE, 31'h7F00_0001);
      reseed_queue.push_back(1'b0);
      reseed_queue.push_back(1'b0);
      drain();

      for (int phase = 0; phase < 10; phase++) begin
         write_reg(REG_SEED, pick_seed());
         write_reg(REG_POS_SCALE, pick_scale());
         write_reg(REG_VEL_SCALE, pick_scale());
         if (phase % 3 == 0) begin
            send_gap_pct = 0;
            take_stall_pct = 0;
         end else begin
            send_gap_pct = $urandom_range(15, 60);
            take_stall_pct = $urandom_range(15, 60);
         end
         queue_bodies($urandom_range(30, 50), 12);
         drain();
         queue_bodies($urandom_range(30, 50), 12);
         drain();
      end

      if (error_count == 0)
         $display("tb_top: clean");
      else
         $display("tb_top: errors");
      $finish;
   end
endmodule
